### rtl/jss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types and constants of the Jacobi stencil sweep block: beat payloads,
// configuration register indexes and the records passed between the parts.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int VALUE_W = 32;           // Q16.16 sample
  localparam int COORD_W = 10;           // emitted row / column index
  localparam int ERR_W   = 31;           // saturated absolute change
  localparam int DIM_W   = 11;           // geometry register
  localparam int SUM_W   = VALUE_W + 2;  // exact four-term sum
  localparam int DIFF_W  = VALUE_W + 1;  // exact old - new

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd100;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [0:0] {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    value_t value;
  } in_item_t;

  typedef struct packed {
    value_t              new_value;
    logic [COORD_W-1:0]  out_row;
    logic [COORD_W-1:0]  out_col;
    logic [ERR_W-1:0]    max_error;
    logic                last_of_sweep;
  } out_item_t;

  // Neighborhood of one grid point, gathered when the sample below it arrives.
  typedef struct packed {
    value_t up;
    value_t left;
    value_t right;
    value_t below;
    value_t center;
  } stencil_ops_t;

  // Control that travels with each sample through the arithmetic stages.
  typedef struct packed {
    logic                emit;   // interior point, produces a result
    logic                start;  // first sample of a sweep
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                last;
  } point_tag_t;

endpackage
`default_nettype wire

### rtl/jss_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jss_stream_if
// Valid/ready stream channel; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface jss_stream_if #(
  parameter type item_t = logic
);

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

### rtl/jss_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jss_line_store
// The two previous raster lines: middle line with two read ports (center and
// right neighbor), upper line with one. One write per line per cycle.
// ----------------------------------------------------------------------------
module jss_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          wr_addr,
  input  logic [jss_pkg::VALUE_W-1:0] wr_mid,
  input  logic [jss_pkg::VALUE_W-1:0] wr_up,
  input  logic [AW-1:0]          rd_addr,
  input  logic [AW-1:0]          rd_addr_right,
  output logic [jss_pkg::VALUE_W-1:0] mid_q,
  output logic [jss_pkg::VALUE_W-1:0] right_q,
  output logic [jss_pkg::VALUE_W-1:0] up_q
);
  import jss_pkg::*;

  logic [VALUE_W-1:0] mid_mem [DEPTH];
  logic [VALUE_W-1:0] up_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mid_mem[wr_addr] <= wr_mid;
    end
    mid_q   <= mid_mem[rd_addr];
    right_q <= mid_mem[rd_addr_right];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      up_mem[wr_addr] <= wr_up;
    end
    up_q <= up_mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/jss_relax_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jss_relax_pipe
// Arithmetic stages: four-term sum and quarter, absolute change with
// saturation, then running maximum and the result register.
// ----------------------------------------------------------------------------
module jss_relax_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  jss_pkg::stencil_ops_t ops,
  input  jss_pkg::point_tag_t   tag,
  input  logic                  clear_max,
  output logic                  can_load,
  jss_stream_if.source          results
);
  import jss_pkg::*;

  // stage 1: operands
  logic          v1;
  stencil_ops_t  ops1;
  point_tag_t    tag1;
  // stage 2: quarter sum
  logic          v2;
  value_t        q2;
  value_t        ctr2;
  point_tag_t    tag2;
  // stage 3: magnitude of change
  logic          v3;
  value_t        q3;
  logic [ERR_W-1:0] mag3;
  point_tag_t    tag3;
  // result register and sweep maximum
  logic          ov;
  out_item_t     out_r;
  logic [ERR_W-1:0] rmax;

  logic              take3, adv3, adv2, adv1;
  logic [SUM_W-1:0]  sum1;
  logic [DIFF_W-1:0] diff2, mag2;
  logic [ERR_W-1:0]  mag_sat2, base3, max3;

  // S3 leaves when its slot in the result register frees, or at once if it
  // carries no result.
  assign take3    = v3 && (!tag3.emit || !ov || results.ready);
  assign adv3     = !v3 || take3;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign can_load = adv1;

  assign sum1 = {{2{ops1.up[VALUE_W-1]}},     ops1.up}
              + {{2{ops1.left[VALUE_W-1]}},   ops1.left}
              + {{2{ops1.right[VALUE_W-1]}},  ops1.right}
              + {{2{ops1.below[VALUE_W-1]}},  ops1.below};

  assign diff2    = {ctr2[VALUE_W-1], ctr2} - {q2[VALUE_W-1], q2};
  assign mag2     = diff2[DIFF_W-1] ? (~diff2 + DIFF_W'(1)) : diff2;
  assign mag_sat2 = (mag2[DIFF_W-1:ERR_W] != '0) ? '1 : mag2[ERR_W-1:0];

  assign base3 = tag3.start ? '0 : rmax;
  assign max3  = (mag3 > base3) ? mag3 : base3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= load;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ops1 <= ops;
      tag1 <= tag;
    end
    if (adv2 && v1) begin
      q2   <= value_t'(sum1[SUM_W-1:2]);
      ctr2 <= ops1.center;
      tag2 <= tag1;
    end
    if (adv3 && v2) begin
      q3   <= q2;
      mag3 <= mag_sat2;
      tag3 <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov   <= 1'b0;
      rmax <= '0;
    end else begin
      if (clear_max) begin
        rmax <= '0;
      end else if (take3) begin
        rmax <= tag3.emit ? max3 : base3;
      end
      if (take3 && tag3.emit) begin
        ov <= 1'b1;
      end else if (results.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take3 && tag3.emit) begin
      out_r.new_value     <= q3;
      out_r.out_row       <= tag3.row;
      out_r.out_col       <= tag3.col;
      out_r.max_error     <= max3;
      out_r.last_of_sweep <= tag3.last;
    end
  end

  assign results.valid   = ov;
  assign results.payload = out_r;

endmodule
`default_nettype wire

### rtl/jacobi_stencil_sweep_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep_top
// One Jacobi four-neighbor relaxation sweep over a raster-order sample stream.
// ----------------------------------------------------------------------------
// Feed the grid one Q16.16 sample per beat, row 0 first, column 0 first. For
// every interior point the block returns the floor of the four-neighbor sum
// divided by four, its row and column, the saturated running maximum of
// |old - new| for this sweep, and a flag on the last interior point. Border
// samples produce no result. The block takes one sample every clock cycle
// while the results stream is not stalled; the rate is set by the middle-line
// memory, which serves the center and right neighbor through two read ports
// while the sample is written back in the same cycle. A result passes the
// operand, quarter-sum and magnitude stages and the result register. The
// memories are not cleared: a sweep only reads entries that it wrote earlier.
// After reset and after every configuration write, samples.ready stays low
// for one cycle while the read ports fetch column 0. A configuration write
// (any index) restarts the sweep; write only when the block is idle. Geometry
// below 3 acts as 3, above the maximum as the maximum.
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep_top #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  jss_pkg::cfg_reg_t           cfg_index,
  input  logic [jss_pkg::DIM_W-1:0]   cfg_data,
  jss_stream_if.sink                  samples,
  jss_stream_if.source                results
);
  import jss_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic [CW-1:0] COL_TOP = CW'(MAX_COLS - 1);

  // Clamp a geometry value and return the index of the last column / row.
  function automatic logic [CW-1:0] last_col(input logic [DIM_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'd3) begin
      return CW'(2);
    end else if (w > 32'(MAX_COLS)) begin
      return CW'(MAX_COLS - 1);
    end else begin
      return CW'(w - 32'd1);
    end
  endfunction

  function automatic logic [RW-1:0] last_row(input logic [DIM_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'd3) begin
      return RW'(2);
    end else if (w > 32'(MAX_ROWS)) begin
      return RW'(MAX_ROWS - 1);
    end else begin
      return RW'(w - 32'd1);
    end
  endfunction

  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic          rd_ok;      // memory read data belongs to the current column
  value_t        left_hold;  // previous center sample

  logic          accept;
  logic          pipe_ready;
  logic [CW-1:0] rd_addr, rd_addr_right;
  value_t        mid_q, right_q, up_q;
  stencil_ops_t  ops;
  point_tag_t    tag;

  assign samples.ready = rd_ok && pipe_ready;
  assign accept        = samples.valid && samples.ready;

  // Raster position of the sample after this one.
  always_comb begin
    if (col == col_last) begin
      col_next = '0;
      row_next = (row == row_last) ? '0 : row + RW'(1);
    end else begin
      col_next = col + CW'(1);
      row_next = row;
    end
  end

  // Prefetch the next column on a beat, otherwise keep refreshing the current
  // one. The right-hand read is only used below the last column.
  assign rd_addr       = accept ? col_next : col;
  assign rd_addr_right = (rd_addr == COL_TOP) ? rd_addr : rd_addr + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= last_col(DIM_RESET);
      row_last <= last_row(DIM_RESET);
      col      <= '0;
      row      <= '0;
      rd_ok    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_COLS: col_last <= last_col(cfg_data);
        REG_GRID_ROWS: row_last <= last_row(cfg_data);
        default: ;
      endcase
      // restart the sweep; read data is stale for one cycle
      col   <= '0;
      row   <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= 1'b1;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_hold <= mid_q;
    end
  end

  // Shift the lines: the center drops to the upper line, the new sample
  // takes its place in the middle line.
  jss_line_store #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_lines (
    .clk           (clk),
    .we            (accept),
    .wr_addr       (col),
    .wr_mid        (samples.payload.value),
    .wr_up         (mid_q),
    .rd_addr       (rd_addr),
    .rd_addr_right (rd_addr_right),
    .mid_q         (mid_q),
    .right_q       (right_q),
    .up_q          (up_q)
  );

  always_comb begin
    ops.up     = up_q;
    ops.left   = left_hold;
    ops.right  = right_q;
    ops.below  = samples.payload.value;
    ops.center = mid_q;

    tag.emit  = (row >= RW'(2)) && (col != '0) && (col != col_last);
    tag.start = (row == '0) && (col == '0);
    tag.row   = COORD_W'(row - RW'(1));
    tag.col   = COORD_W'(col);
    tag.last  = (row == row_last) && (col == col_last - CW'(1));
  end

  jss_relax_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .ops       (ops),
    .tag       (tag),
    .clear_max (cfg_we),
    .can_load  (pipe_ready),
    .results   (results)
  );

endmodule
`default_nettype wire
